// ===== design/irf_pkg.sv =====
// shared types, constants and codes for the ipv4 receive filter
// no dependencies; compiled before every other file of the block
package irf_pkg;

    localparam int unsigned ADDR_W      = 32;
    localparam int unsigned CFG_IDX_W   = 1;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] REG_LOCAL_ADDRESS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SUBNET_MASK   = 1'd1;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETH_HDR_LEN    = 16'd14;
    localparam logic [15:0] MIN_FRAME_LEN  = 16'd34;
    localparam logic [5:0]  IP_HDR_MIN     = 6'd20;
    localparam logic [3:0]  IP_VERSION     = 4'd4;
    localparam logic [15:0] SUM_GOOD       = 16'hFFFF;
    localparam logic [15:0] COUNT_MAX      = 16'hFFFF;

    typedef enum logic [3:0] {
        VERDICT_ACCEPT      = 4'd0,
        VERDICT_SHORT       = 4'd1,
        VERDICT_ETHERTYPE   = 4'd2,
        VERDICT_VERSION     = 4'd3,
        VERDICT_HDR_LEN     = 4'd4,
        VERDICT_CHECKSUM    = 4'd5,
        VERDICT_TOTAL_LEN   = 4'd6,
        VERDICT_UNCONFIGURED = 4'd7,
        VERDICT_NOT_OURS    = 4'd8
    } verdict_t;

    // everything the verdict needs from one finished frame
    typedef struct packed {
        logic [15:0]       frame_len;
        logic [15:0]       ether_type;
        logic [7:0]        version_length;
        logic [15:0]       datagram_length;
        logic [ADDR_W-1:0] destination;
        logic [15:0]       checksum;
    } frame_rec_t;

endpackage

// ===== design/irf_in_if.sv =====
// byte channel into the ipv4 receive filter: valid/ready plus one frame byte
// depends on nothing
interface irf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last_byte;

    modport source (output valid, output frame_byte, output last_byte, input ready);
    modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

// ===== design/irf_out_if.sv =====
// verdict channel out of the ipv4 receive filter: valid/ready plus one verdict
// depends on nothing
interface irf_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] verdict;
    logic       broadcast_hit;

    modport source (output valid, output verdict, output broadcast_hit, input ready);
    modport sink   (input valid, input verdict, input broadcast_hit, output ready);
endinterface

// ===== design/irf_front.sv =====
// byte parser: captures header fields, keeps the header sum and frame length
// depends on irf_pkg; pushes one frame record per last byte
module irf_front
    import irf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  logic [7:0] frame_byte,
    input  logic       last_byte,
    output logic       push,
    output frame_rec_t rec
);

    logic [15:0]       byte_count_reg, byte_count_next;
    logic [15:0]       ether_type_reg, ether_type_next;
    logic [7:0]        version_length_reg, version_length_next;
    logic [15:0]       datagram_length_reg, datagram_length_next;
    logic [ADDR_W-1:0] destination_reg, destination_next;
    logic [15:0]       checksum_reg, checksum_next;
    logic [7:0]        pending_high_reg, pending_high_next;

    logic [15:0] pos;
    logic [15:0] offset;
    logic [3:0]  ihl;
    logic [5:0]  hdr_len;
    logic        in_header;
    logic [16:0] sum_wide;
    logic [15:0] sum_folded;

    always_comb
    begin
        pos    = byte_count_reg;
        offset = pos - ETH_HDR_LEN;

        ether_type_next      = ether_type_reg;
        version_length_next  = version_length_reg;
        datagram_length_next = datagram_length_reg;
        destination_next     = destination_reg;
        checksum_next        = checksum_reg;
        pending_high_next    = pending_high_reg;

        if (pos == 16'd12 || pos == 16'd13)
            ether_type_next = {ether_type_reg[7:0], frame_byte};
        if (pos == 16'd14)
            version_length_next = frame_byte;
        if (pos == 16'd16 || pos == 16'd17)
            datagram_length_next = {datagram_length_reg[7:0], frame_byte};
        if (pos >= 16'd30 && pos <= 16'd33)
            destination_next = {destination_reg[ADDR_W-9:0], frame_byte};

        // header length comes from the version byte itself when it arrives
        ihl       = (pos == 16'd14) ? frame_byte[3:0] : version_length_reg[3:0];
        hdr_len   = {ihl, 2'b00};
        in_header = (pos >= ETH_HDR_LEN) && (offset < {10'd0, hdr_len});

        // ones' complement add with end-around carry
        sum_wide   = {1'b0, checksum_reg} + {1'b0, pending_high_reg, frame_byte};
        sum_folded = sum_wide[16] ? (sum_wide[15:0] + 16'd1) : sum_wide[15:0];

        if (in_header)
        begin
            if (!offset[0])
                pending_high_next = frame_byte;
            else
                checksum_next = sum_folded;
        end

        byte_count_next = (pos == COUNT_MAX) ? pos : (pos + 16'd1);

        rec.frame_len       = byte_count_next;
        rec.ether_type      = ether_type_next;
        rec.version_length  = version_length_next;
        rec.datagram_length = datagram_length_next;
        rec.destination     = destination_next;
        rec.checksum        = checksum_next;
        push                = take && last_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg      <= '0;
            ether_type_reg      <= '0;
            version_length_reg  <= '0;
            datagram_length_reg <= '0;
            destination_reg     <= '0;
            checksum_reg        <= '0;
            pending_high_reg    <= '0;
        end
        else if (take)
        begin
            if (last_byte)
            begin
                // frame done, start the next one clean
                byte_count_reg      <= '0;
                ether_type_reg      <= '0;
                version_length_reg  <= '0;
                datagram_length_reg <= '0;
                destination_reg     <= '0;
                checksum_reg        <= '0;
                pending_high_reg    <= '0;
            end
            else
            begin
                byte_count_reg      <= byte_count_next;
                ether_type_reg      <= ether_type_next;
                version_length_reg  <= version_length_next;
                datagram_length_reg <= datagram_length_next;
                destination_reg     <= destination_next;
                checksum_reg        <= checksum_next;
                pending_high_reg    <= pending_high_next;
            end
        end
    end

endmodule

// ===== design/irf_queue.sv =====
// short queue of finished frame records between parser and verdict stage
// depends on irf_pkg
module irf_queue
    import irf_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  frame_rec_t push_rec,
    input  logic       pop,
    output frame_rec_t head_rec,
    output logic       empty,
    output logic       full
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    frame_rec_t       entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        empty    = (count_reg == '0);
        full     = (count_reg == FULL_CNT);
        head_rec = entries[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : (wr_ptr_reg + PTR_W'(1));
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : (rd_ptr_reg + PTR_W'(1));
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries[wr_ptr_reg] <= push_rec;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue pushed while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue popped while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue count beyond depth");

endmodule

// ===== design/irf_back.sv =====
// verdict stage: checks one frame record in order and holds the result
// depends on irf_pkg; output register doubles as the skid toward the sink
module irf_back
    import irf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  frame_rec_t        rec,
    input  logic              rec_avail,
    output logic              pop,
    input  logic [ADDR_W-1:0] local_address,
    input  logic [ADDR_W-1:0] subnet_mask,
    input  logic              out_ready,
    output logic              out_valid,
    output logic [3:0]        verdict,
    output logic              broadcast_hit
);

    logic              valid_reg;
    verdict_t          verdict_reg, verdict_next;
    logic              bcast_reg, bcast_next;
    logic [15:0]       payload_len;
    logic [15:0]       hdr_len;
    logic [ADDR_W-1:0] directed;
    logic              is_bcast;

    always_comb
    begin
        payload_len = rec.frame_len - ETH_HDR_LEN;
        hdr_len     = {10'd0, rec.version_length[3:0], 2'b00};
        directed    = local_address | ~subnet_mask;
        is_bcast    = (rec.destination == directed) || (&rec.destination);
        bcast_next  = 1'b0;

        if (rec.frame_len < MIN_FRAME_LEN)
            verdict_next = VERDICT_SHORT;
        else if (rec.ether_type != ETHERTYPE_IPV4)
            verdict_next = VERDICT_ETHERTYPE;
        else if (rec.version_length[7:4] != IP_VERSION)
            verdict_next = VERDICT_VERSION;
        else if (hdr_len < {10'd0, IP_HDR_MIN} || hdr_len > payload_len)
            verdict_next = VERDICT_HDR_LEN;
        else if (rec.checksum != SUM_GOOD)
            verdict_next = VERDICT_CHECKSUM;
        else if (rec.datagram_length < hdr_len || rec.datagram_length > payload_len)
            verdict_next = VERDICT_TOTAL_LEN;
        else if (local_address == '0)
            verdict_next = VERDICT_UNCONFIGURED;
        else if (rec.destination != local_address && !is_bcast)
            verdict_next = VERDICT_NOT_OURS;
        else
        begin
            verdict_next = VERDICT_ACCEPT;
            bcast_next   = is_bcast;
        end

        pop           = rec_avail && (!valid_reg || out_ready);
        out_valid     = valid_reg;
        verdict       = verdict_reg;
        broadcast_hit = bcast_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (pop)
            valid_reg <= 1'b1;
        else if (out_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            verdict_reg <= verdict_next;
            bcast_reg   <= bcast_next;
        end
    end

    a_bcast_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && bcast_reg) |-> (verdict_reg == VERDICT_ACCEPT))
        else $error("broadcast flag on a rejected frame");

    a_result_from_record: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(valid_reg) |-> $past(pop))
        else $error("result appeared without a frame record");

    a_pop_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (rec_avail && (!valid_reg || out_ready)))
        else $error("record taken while result still held");

endmodule

// ===== design/ipv4_receive_filter.sv =====
// ipv4 receive filter, top level
// one frame byte per item in, one verdict item out per frame
// channels: frame (bytes with a last-byte mark) and result (verdict, broadcast flag)
// configuration: cfg_we/cfg_index/cfg_data write local_address (0) and subnet_mask (1)
// write configuration only while no frame is in flight
// throughput: one byte per cycle while the record queue is not full, including one-byte frames
// path: a finished frame's record is written into the record queue, then checked
//   into the result register once the result side is free; the queue and the
//   result register let the parser keep taking bytes while a verdict waits
// the parser (irf_front) updates its header captures and ones' complement sum
//   every byte; on the last byte it pushes a frame record into irf_queue
// irf_back checks the record in priority order into the result register
// frame.ready drops only when the record queue is full, which happens when the
//   result sink stalls across several frame ends
// reset: all frame state, the queue and the result valid clear; both
//   configuration registers return to zero (unconfigured)
// depends on irf_pkg, irf_in_if, irf_out_if, irf_front, irf_queue, irf_back
module ipv4_receive_filter
    import irf_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    irf_in_if.sink               frame,
    irf_out_if.source            result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data
);

    // configuration registers
    logic [ADDR_W-1:0] local_address_reg;
    logic [ADDR_W-1:0] subnet_mask_reg;

    // parser to queue
    logic       take;
    logic       push;
    frame_rec_t push_rec;

    // queue to verdict stage
    frame_rec_t head_rec;
    logic       q_empty;
    logic       q_full;
    logic       pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_address_reg <= '0;
            subnet_mask_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LOCAL_ADDRESS: local_address_reg <= cfg_data;
                REG_SUBNET_MASK:   subnet_mask_reg   <= cfg_data;
                default:           ;
            endcase
        end
    end

    // bytes flow as long as the queue can take a finished frame
    assign frame.ready = !q_full;
    assign take        = frame.valid && frame.ready;

    irf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .frame_byte (frame.frame_byte),
        .last_byte  (frame.last_byte),
        .push       (push),
        .rec        (push_rec)
    );

    irf_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .head_rec (head_rec),
        .empty    (q_empty),
        .full     (q_full)
    );

    irf_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .rec           (head_rec),
        .rec_avail     (!q_empty),
        .pop           (pop),
        .local_address (local_address_reg),
        .subnet_mask   (subnet_mask_reg),
        .out_ready     (result.ready),
        .out_valid     (result.valid),
        .verdict       (result.verdict),
        .broadcast_hit (result.broadcast_hit)
    );

endmodule

// ===== tb/irf_checker.sv =====
// verdict predictor and scoreboard for the ipv4 receive filter testbench
// watches the frame, result and configuration ports; depends on irf_pkg
module irf_checker
    import irf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 frame_valid,
    input  logic                 frame_ready,
    input  logic [7:0]           frame_byte,
    input  logic                 last_byte,
    input  logic                 result_valid,
    input  logic                 result_ready,
    input  logic [3:0]           verdict,
    input  logic                 broadcast_hit,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data,
    output int                   mismatches,
    output int                   awaited,
    output int                   verdicts_seen
);

    typedef struct packed {
        logic [3:0] verdict;
        logic       bcast;
    } verdict_rec_t;

    logic [31:0]  local_addr;
    logic [31:0]  net_mask;
    logic [15:0]  byte_cnt;
    logic [15:0]  eth_type;
    logic [7:0]   ver_ihl;
    logic [15:0]  total_len;
    logic [31:0]  dst_addr;
    logic [15:0]  hdr_sum;
    logic [7:0]   word_hi;
    verdict_rec_t pending_verdicts[$];
    int           miss_cnt;
    int           seen_cnt;

    function automatic logic [15:0] ones_sum(logic [15:0] acc, logic [15:0] word);
        logic [16:0] s;
        s = {1'b0, acc} + {1'b0, word};
        return s[16] ? s[15:0] + 16'd1 : s[15:0];
    endfunction

    task automatic clear_frame();
        byte_cnt  = '0;
        eth_type  = '0;
        ver_ihl   = '0;
        total_len = '0;
        dst_addr  = '0;
        hdr_sum   = '0;
        word_hi   = '0;
    endtask

    // first failing check wins
    function automatic verdict_rec_t frame_verdict(logic [15:0] flen);
        int           payload;
        int           hlen;
        logic [31:0]  directed;
        logic         bc;
        verdict_rec_t r;
        payload  = int'(flen) - int'(ETH_HDR_LEN);
        hlen     = int'(ver_ihl[3:0]) * 4;
        directed = local_addr | ~net_mask;
        bc       = (dst_addr == directed) || (dst_addr == 32'hFFFF_FFFF);
        r.bcast  = 1'b0;
        if (flen < MIN_FRAME_LEN)
            r.verdict = VERDICT_SHORT;
        else if (eth_type != ETHERTYPE_IPV4)
            r.verdict = VERDICT_ETHERTYPE;
        else if (ver_ihl[7:4] != IP_VERSION)
            r.verdict = VERDICT_VERSION;
        else if (hlen < int'(IP_HDR_MIN) || hlen > payload)
            r.verdict = VERDICT_HDR_LEN;
        else if (hdr_sum != SUM_GOOD)
            r.verdict = VERDICT_CHECKSUM;
        else if (int'(total_len) < hlen || int'(total_len) > payload)
            r.verdict = VERDICT_TOTAL_LEN;
        else if (local_addr == '0)
            r.verdict = VERDICT_UNCONFIGURED;
        else if (dst_addr != local_addr && !bc)
            r.verdict = VERDICT_NOT_OURS;
        else
        begin
            r.verdict = VERDICT_ACCEPT;
            r.bcast   = bc;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        verdict_rec_t want;
        int           pos;
        int           hlen_now;
        logic [7:0]   ihl_src;
        if (!rst_n)
        begin
            local_addr = '0;
            net_mask   = '0;
            clear_frame();
            pending_verdicts.delete();
            miss_cnt = 0;
            seen_cnt = 0;
        end
        else
        begin
            // result side first: a result can never belong to this edge's frame end
            if (result_valid && result_ready)
            begin
                seen_cnt++;
                if (pending_verdicts.size() == 0)
                begin
                    miss_cnt++;
                    if (miss_cnt <= 10)
                        $display("unexpected result: verdict %0d bcast %0b",
                                 verdict, broadcast_hit);
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    if (verdict !== want.verdict || broadcast_hit !== want.bcast)
                    begin
                        miss_cnt++;
                        if (miss_cnt <= 10)
                            $display("mismatch: verdict %0d bcast %0b, expected %0d %0b",
                                     verdict, broadcast_hit, want.verdict, want.bcast);
                    end
                end
            end
            if (frame_valid && frame_ready)
            begin
                pos = int'(byte_cnt);
                if (pos == 12 || pos == 13)
                    eth_type = {eth_type[7:0], frame_byte};
                if (pos == 14)
                    ver_ihl = frame_byte;
                if (pos == 16 || pos == 17)
                    total_len = {total_len[7:0], frame_byte};
                if (pos >= 30 && pos <= 33)
                    dst_addr = {dst_addr[23:0], frame_byte};
                ihl_src  = (pos == 14) ? frame_byte : ver_ihl;
                hlen_now = int'(ihl_src[3:0]) * 4;
                if (pos >= 14 && pos - 14 < hlen_now)
                begin
                    if (((pos - 14) % 2) == 0)
                        word_hi = frame_byte;
                    else
                        hdr_sum = ones_sum(hdr_sum, {word_hi, frame_byte});
                end
                if (byte_cnt != COUNT_MAX)
                    byte_cnt = byte_cnt + 16'd1;
                if (last_byte)
                begin
                    pending_verdicts.push_back(frame_verdict(byte_cnt));
                    clear_frame();
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == REG_LOCAL_ADDRESS)
                    local_addr = cfg_data;
                else if (cfg_index == REG_SUBNET_MASK)
                    net_mask = cfg_data;
            end
        end
        mismatches    <= miss_cnt;
        awaited       <= pending_verdicts.size();
        verdicts_seen <= seen_cnt;
    end

endmodule

// ===== tb/ipv4_receive_filter_tb.sv =====
// testbench top for the ipv4 receive filter: builds frames, drives both channels
// and the register port, and reports the verdict; depends on irf_pkg, the channel
// interfaces, ipv4_receive_filter and irf_checker
module ipv4_receive_filter_tb;
    import irf_pkg::*;

    localparam int LIMIT        = 100_000;
    localparam int RANDOM_BYTES = 800;

    logic                 clk   = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ADDR_W-1:0]    cfg_data;

    irf_in_if  frame_ch ();
    irf_out_if result_ch ();

    int          sender_idle = 0;   // percent of cycles the byte source holds off
    int          sink_stall  = 0;   // percent of cycles the verdict sink holds off
    int          cycles;
    int          bytes_sent  = 0;
    int          frames_sent = 0;
    int          settings    = 0;
    int          mismatches;
    int          awaited;
    int          verdicts_seen;
    logic [7:0]  pkt[$];            // frame under construction
    logic [31:0] local_ip;          // what the address registers now hold
    logic [31:0] mask_ip;

    ipv4_receive_filter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .frame     (frame_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    irf_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .frame_valid   (frame_ch.valid),
        .frame_ready   (frame_ch.ready),
        .frame_byte    (frame_ch.frame_byte),
        .last_byte     (frame_ch.last_byte),
        .result_valid  (result_ch.valid),
        .result_ready  (result_ch.ready),
        .verdict       (result_ch.verdict),
        .broadcast_hit (result_ch.broadcast_hit),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .awaited       (awaited),
        .verdicts_seen (verdicts_seen)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // verdict sink: random back-pressure at the current stall rate
    always @(posedge clk)
        result_ch.ready <= ($urandom_range(99) >= sink_stall);

    // watchdog: a hung handshake or a lost verdict ends here
    initial
    begin
        cycles = 0;
        while (cycles < LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // one frame byte; a gap may come first, so valid never drops and rises in one step
    task automatic send_byte(input logic [7:0] b, input logic l);
        if ($urandom_range(99) < sender_idle)
        begin
            frame_ch.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < sender_idle)
                @(posedge clk);
        end
        frame_ch.valid      <= 1'b1;
        frame_ch.frame_byte <= b;
        frame_ch.last_byte  <= l;
        @(posedge clk);
        while (!frame_ch.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_frame();
        int i;
        for (i = 0; i < pkt.size(); i++)
            send_byte(pkt[i], i == pkt.size() - 1);
        frames_sent++;
    endtask

    // stop sending and wait until every predicted verdict has come out;
    // the first edge lets the checker count a frame that ended this step
    task automatic drain();
        frame_ch.valid <= 1'b0;
        @(posedge clk);
        while (awaited != 0)
            @(posedge clk);
    endtask

    // both address registers, written only with the block idle
    task automatic set_addresses(input logic [31:0] la, input logic [31:0] sm);
        drain();
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_LOCAL_ADDRESS;
        cfg_data  <= la;
        @(posedge clk);
        cfg_index <= REG_SUBNET_MASK;
        cfg_data  <= sm;
        @(posedge clk);
        cfg_we   <= 1'b0;
        local_ip = la;
        mask_ip  = sm;
        settings++;
    endtask

    // ethernet + ipv4 frame with a correct header checksum, well-formed for ihl of 5 or more;
    // len_adj skews the total length field away from the true datagram size
    task automatic make_ipv4(input logic [3:0] ihl, input int body_len,
                             input logic [31:0] dst, input int len_adj);
        int          hdr_bytes;
        int          i;
        logic [31:0] s;
        logic [15:0] tot;
        hdr_bytes = (ihl < 4'd5) ? 20 : int'(ihl) * 4;
        tot       = 16'(hdr_bytes + body_len + len_adj);
        pkt.delete();
        repeat (12) pkt.push_back($urandom_range(255));     // mac addresses
        pkt.push_back(ETHERTYPE_IPV4[15:8]);
        pkt.push_back(ETHERTYPE_IPV4[7:0]);
        pkt.push_back({IP_VERSION, ihl});
        pkt.push_back($urandom_range(255));                  // tos
        pkt.push_back(tot[15:8]);
        pkt.push_back(tot[7:0]);
        repeat (6) pkt.push_back($urandom_range(255));      // id, flags, ttl, protocol
        pkt.push_back(8'h00);                                // checksum, filled below
        pkt.push_back(8'h00);
        repeat (4) pkt.push_back($urandom_range(255));      // source address
        pkt.push_back(dst[31:24]);
        pkt.push_back(dst[23:16]);
        pkt.push_back(dst[15:8]);
        pkt.push_back(dst[7:0]);
        repeat (hdr_bytes - 20) pkt.push_back($urandom_range(255));  // options
        s = '0;
        for (i = 0; i < int'(ihl) * 4; i += 2)
            s += {16'h0, pkt[14 + i], pkt[15 + i]};
        s = (s & 32'hFFFF) + (s >> 16);
        s = (s & 32'hFFFF) + (s >> 16);
        pkt[24] = ~s[15:8];
        pkt[25] = ~s[7:0];
        repeat (body_len) pkt.push_back($urandom_range(255));
    endtask

    // mostly legal frames with random content, the rest noise, bit flips and
    // truncations so every check gets its share
    task automatic random_frame();
        int          kind;
        int          body;
        int          adj;
        int          cut;
        int          k;
        logic [3:0]  ihl;
        logic [31:0] dst;
        kind = $urandom_range(99);
        case ($urandom_range(3))
            0:       dst = local_ip;
            1:       dst = local_ip | ~mask_ip;
            2:       dst = 32'hFFFF_FFFF;
            default: dst = $urandom;
        endcase
        if (kind < 12)
        begin
            pkt.delete();
            repeat ($urandom_range(1, 40)) pkt.push_back($urandom_range(255));
            // half of the noise longer than 14 bytes gets the ipv4 ethertype
            if ($urandom_range(1) == 1 && pkt.size() > 14)
            begin
                pkt[12] = ETHERTYPE_IPV4[15:8];
                pkt[13] = ETHERTYPE_IPV4[7:0];
            end
        end
        else
        begin
            ihl  = ($urandom_range(4) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(5, 7));
            body = $urandom_range(0, 8);
            case ($urandom_range(19))
                0:       adj = -(body + 1 + $urandom_range(3));
                1:       adj = 1 + $urandom_range(3);
                default: adj = 0;
            endcase
            make_ipv4(ihl, body, dst, adj);
            if (kind < 22)
            begin
                k      = $urandom_range(pkt.size() - 1);
                pkt[k] = pkt[k] ^ (8'd1 << $urandom_range(7));
            end
            else if (kind < 30)
            begin
                cut = $urandom_range(1, pkt.size() - 1);
                while (pkt.size() > cut)
                    void'(pkt.pop_back());
            end
        end
    endtask

    initial
    begin : stimulus
        int phase;
        int start_bytes;
        int start_frames;
        int i;

        cfg_we              <= 1'b0;
        cfg_index           <= REG_LOCAL_ADDRESS;
        cfg_data            <= '0;
        frame_ch.valid      <= 1'b0;
        frame_ch.frame_byte <= '0;
        frame_ch.last_byte  <= 1'b0;
        local_ip = '0;
        mask_ip  = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part, no idling on either side ----

        // one-byte frames at both byte extremes: too short
        pkt.delete();
        pkt.push_back(8'hFF);
        send_frame();
        pkt.delete();
        pkt.push_back(8'h00);
        send_frame();
        // legal frames while no local address is set: unconfigured
        make_ipv4(4'd5, 0, $urandom, 0);
        send_frame();
        make_ipv4(4'd5, 2, 32'hFFFF_FFFF, 0);
        send_frame();

        set_addresses(32'hC0A8_0A05, 32'hFFFF_FF00);
        // minimum legal frame, exactly 34 bytes, unicast to us
        make_ipv4(4'd5, 0, local_ip, 0);
        send_frame();
        // directed and limited broadcast
        make_ipv4(4'd5, 3, local_ip | ~mask_ip, 0);
        send_frame();
        make_ipv4(4'd5, 1, 32'hFFFF_FFFF, 0);
        send_frame();
        // somebody else's address
        make_ipv4(4'd5, 1, 32'hC0A8_0B05, 0);
        send_frame();
        // arp ethertype
        make_ipv4(4'd5, 0, local_ip, 0);
        pkt[13] = 8'h06;
        send_frame();
        // version 6
        make_ipv4(4'd5, 0, local_ip, 0);
        pkt[14] = {4'd6, pkt[14][3:0]};
        send_frame();
        // header length below the minimum
        make_ipv4(4'd4, 4, local_ip, 0);
        send_frame();
        // largest header length reaching past the end of the frame
        make_ipv4(4'd15, 0, local_ip, 0);
        while (pkt.size() > 60)
            void'(pkt.pop_back());
        send_frame();
        // checksum off by one bit
        make_ipv4(4'd5, 2, local_ip, 0);
        pkt[24] = pkt[24] ^ 8'h01;
        send_frame();
        // total length below the header, and beyond the payload
        make_ipv4(4'd5, 4, local_ip, -5);
        send_frame();
        make_ipv4(4'd5, 4, local_ip, 1);
        send_frame();
        // options in the header, still accepted
        make_ipv4(4'd6, 2, local_ip, 0);
        send_frame();
        // 33 bytes: one short of the minimum
        make_ipv4(4'd5, 0, local_ip, 0);
        void'(pkt.pop_back());
        send_frame();

        // all-ones mask: directed broadcast is the local address itself
        set_addresses(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        make_ipv4(4'd5, 0, 32'hFFFF_FFFF, 0);
        send_frame();
        make_ipv4(4'd5, 0, 32'h0A00_0001, 0);
        send_frame();

        // all-zero mask: directed broadcast is all ones
        set_addresses(32'h0000_0001, 32'h0000_0000);
        make_ipv4(4'd5, 1, local_ip, 0);
        send_frame();

        // ---- random part: four idling phases, each with its own addresses ----
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    sender_idle = 0;
                    sink_stall  = 0;
                    set_addresses($urandom | 32'h1, 32'hFFFF_FF00);
                end
                1:
                begin
                    sender_idle = 72;
                    sink_stall  = 0;
                    set_addresses($urandom | 32'h1, 32'h0000_0000);
                end
                2:
                begin
                    sender_idle = 0;
                    sink_stall  = 72;
                    set_addresses($urandom | 32'h1, $urandom);
                end
                default:
                begin
                    sender_idle = 31;
                    sink_stall  = 31;
                    set_addresses(32'hFFFF_FFFF, 32'hFFFF_FFFF);
                end
            endcase
            start_bytes  = bytes_sent;
            start_frames = frames_sent;
            while (bytes_sent - start_bytes < RANDOM_BYTES / 4 ||
                   frames_sent - start_frames < 5)
            begin
                random_frame();
                send_frame();
                // now and then hold off until the block has nothing left to say
                if ($urandom_range(15) == 0)
                    drain();
            end
        end

        // ---- wind down ----
        drain();
        repeat (8) @(posedge clk);
        $display("covered %0d frames, %0d bytes, %0d verdicts compared", frames_sent,
                 bytes_sent, verdicts_seen);
        $display("over %0d address settings and four idling mixes", settings);
        if (mismatches == 0 && awaited == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
